// ===== rtl/clcd_pkg.sv =====
// Shared types, constants and the power-up table for the character LCD
// expander driver. No dependencies; imported by every module of the block.
package clcd_pkg;

    // Sizing
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int LINE_LEN_W      = 6;
    localparam logic [LINE_LEN_W-1:0] LINE_LEN_RST = 6'd16;
    localparam logic [LINE_LEN_W-1:0] COL_MAX      = 6'd63;

    // Input operation codes (carried in tuser)
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_INIT = 1'b1;

    // Control characters
    localparam logic [7:0] CHR_BEL = 8'h07;
    localparam logic [7:0] CHR_BS  = 8'h08;
    localparam logic [7:0] CHR_TAB = 8'h09;
    localparam logic [7:0] CHR_LF  = 8'h0A;
    localparam logic [7:0] CHR_CR  = 8'h0D;

    // LCD commands
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h02;
    localparam logic [7:0] CMD_LINE2 = 8'h80 | 8'h40;

    // Waits after an expander byte, in microseconds
    localparam logic [11:0] DLY_NONE   = 12'd0;
    localparam logic [11:0] DLY_E_HIGH = 12'd1;
    localparam logic [11:0] DLY_E_LOW  = 12'd50;
    localparam logic [11:0] DLY_LONG   = 12'd2050;

    // Power-up sequence last step index and leading raw bytes (no backlight bit)
    localparam logic [4:0] INIT_LAST      = 5'd30;
    localparam logic [4:0] INIT_RAW_STEPS = 5'd2;

    // Kind of work handed from front to back
    typedef enum logic [1:0] {
        KIND_INIT,
        KIND_RAW,
        KIND_LCD
    } t_kind;

    // One queued job. KIND_LCD sends an optional long command, then val.
    typedef struct packed {
        t_kind      kind;
        logic       bl;
        logic       has_first;
        logic [7:0] first_val;
        logic [7:0] val;
        logic       rs;
        logic       is_long;
        logic       eos;
    } t_job;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_head;

    typedef struct packed {
        logic [11:0] delay;
        logic [7:0]  data;
    } t_rom_word;

    // Power-up sequence; steps from 26 on already carry the backlight bit
    function automatic t_rom_word init_rom(input logic [4:0] idx);
        t_rom_word w;
        case (idx)
            5'd0:    w = '{12'd0,    8'h00};
            5'd1:    w = '{12'd1000, 8'h00};
            5'd2:    w = '{12'd1,    8'h34};
            5'd3:    w = '{12'd1050, 8'h30};
            5'd4:    w = '{12'd1,    8'h34};
            5'd5:    w = '{12'd1050, 8'h30};
            5'd6:    w = '{12'd1,    8'h34};
            5'd7:    w = '{12'd1050, 8'h30};
            5'd8:    w = '{12'd1,    8'h24};
            5'd9:    w = '{12'd1050, 8'h20};
            5'd10:   w = '{12'd1,    8'h24};
            5'd11:   w = '{12'd50,   8'h20};
            5'd12:   w = '{12'd1,    8'h84};
            5'd13:   w = '{12'd1050, 8'h80};
            5'd14:   w = '{12'd1,    8'h04};
            5'd15:   w = '{12'd50,   8'h00};
            5'd16:   w = '{12'd1,    8'hC4};
            5'd17:   w = '{12'd1050, 8'hC0};
            5'd18:   w = '{12'd1,    8'h04};
            5'd19:   w = '{12'd50,   8'h00};
            5'd20:   w = '{12'd1,    8'h64};
            5'd21:   w = '{12'd2050, 8'h60};
            5'd22:   w = '{12'd1,    8'h04};
            5'd23:   w = '{12'd50,   8'h00};
            5'd24:   w = '{12'd1,    8'h14};
            5'd25:   w = '{12'd2050, 8'h10};
            5'd26:   w = '{12'd0,    8'h08};
            5'd27:   w = '{12'd1,    8'h0C};
            5'd28:   w = '{12'd50,   8'h08};
            5'd29:   w = '{12'd1,    8'h2C};
            5'd30:   w = '{12'd2050, 8'h28};
            default: w = '{12'd0,    8'h00};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/clcd_front.sv =====
// Front end: accepts input transactions, tracks cursor column and backlight,
// classifies each byte into a job for the queue. Depends on clcd_pkg.
module clcd_front
    import clcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] char_byte
    input  logic                  i_s_tuser,   // [0] op
    input  logic                  i_s_tlast,   // end_of_string
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [LINE_LEN_W-1:0] i_cfg_data,
    input  logic                  i_full,
    output logic                  o_push,
    output t_job                  o_job
);

    logic [LINE_LEN_W-1:0] r_line_len;
    logic [LINE_LEN_W-1:0] r_column, n_column;
    logic                  r_backlight, n_backlight;
    logic                  accept;
    logic                  drop;
    logic [LINE_LEN_W:0]   col_lim;

    assign o_s_tready  = !i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_push      = accept && !drop;

    // Column saturates at line_length+1, capped at the counter range
    assign col_lim = ({1'b0, r_line_len} + 7'd1 > {1'b0, COL_MAX}) ?
                     {1'b0, COL_MAX} : {1'b0, r_line_len} + 7'd1;

    // Classify the incoming byte
    always_comb begin
        o_job           = '0;
        o_job.kind      = KIND_LCD;
        o_job.bl        = r_backlight;
        o_job.eos       = i_s_tlast;
        drop            = 1'b0;
        n_column        = r_column;
        n_backlight     = r_backlight;
        if (i_s_tuser == OP_INIT) begin
            o_job.kind  = KIND_INIT;
            n_column    = '0;
            n_backlight = 1'b1;
        end else begin
            case (i_s_tdata)
                CHR_CR: begin
                    o_job.has_first = 1'b1;
                    o_job.first_val = CMD_CLEAR;
                    o_job.val       = CMD_HOME;
                    o_job.is_long   = 1'b1;
                    n_column        = '0;
                end
                CHR_BEL: begin
                    o_job.kind  = KIND_RAW;
                    o_job.bl    = 1'b1;
                    n_backlight = 1'b1;
                end
                CHR_BS: begin
                    o_job.kind  = KIND_RAW;
                    o_job.bl    = 1'b0;
                    n_backlight = 1'b0;
                end
                CHR_TAB: begin
                    o_job.val     = CMD_HOME;
                    o_job.is_long = 1'b1;
                    n_column      = '0;
                end
                CHR_LF: begin
                    drop = 1'b1;
                end
                default: begin
                    o_job.has_first = (r_column == r_line_len);
                    o_job.first_val = CMD_LINE2;
                    o_job.val       = i_s_tdata;
                    o_job.rs        = 1'b1;
                    if ({1'b0, r_column} < col_lim) begin
                        n_column = r_column + 6'd1;
                    end
                end
            endcase
        end
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len  <= LINE_LEN_RST;
            r_column    <= '0;
            r_backlight <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_line_len <= i_cfg_data;
            end
            if (accept) begin
                r_column    <= n_column;
                r_backlight <= n_backlight;
            end
        end
    end

endmodule

// ===== rtl/clcd_queue.sv =====
// Job queue between front and back ends, a small circular buffer.
// Depends on clcd_pkg for the job type.
module clcd_queue
    import clcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full       = (r_count == CW'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/clcd_back.sv =====
// Back end: expands the job at the queue head into expander bytes, one per cycle while the
// output is not stalled, into the output register. Depends on clcd_pkg (types, init table).
module clcd_back
    import clcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_head     i_head,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // [7:0] bus_byte, [19:8] delay_us, [23:20] zero
    output logic        o_m_tuser,  // [0] string_done
    output logic        o_m_tlast   // last
);

    logic [4:0]  r_step;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [11:0] r_out_delay;
    logic        r_out_last;
    logic        r_out_done;

    t_job        job;
    t_rom_word   rom;
    logic        fire;
    logic        final_step;
    logic [7:0]  cur_byte;
    logic [11:0] cur_delay;
    logic        unit_second;
    logic [1:0]  k;
    logic [7:0]  lcd_val;
    logic        lcd_rs;
    logic        lcd_long;
    logic [3:0]  nib;
    logic [7:0]  bl_mask;

    assign job     = i_head.job;
    assign fire    = i_head.valid && (!r_out_valid || i_m_tready);
    assign o_pop   = fire && final_step;
    assign bl_mask = {4'b0, job.bl, 3'b0};

    // LCD byte: four expander bytes per unit, optional leading long command
    assign unit_second = !job.has_first || r_step[2];
    assign k           = r_step[1:0];
    assign lcd_val     = unit_second ? job.val : job.first_val;
    assign lcd_rs      = unit_second ? job.rs : 1'b0;
    assign lcd_long    = unit_second ? job.is_long : 1'b1;
    assign nib         = k[1] ? lcd_val[3:0] : lcd_val[7:4];
    assign rom         = init_rom(r_step);

    // Select the byte for the current step
    always_comb begin
        cur_byte   = '0;
        cur_delay  = DLY_NONE;
        final_step = 1'b1;
        case (job.kind)
            KIND_INIT: begin
                cur_byte   = (r_step >= INIT_RAW_STEPS) ? (rom.data | bl_mask) : rom.data;
                cur_delay  = rom.delay;
                final_step = (r_step == INIT_LAST);
            end
            KIND_RAW: begin
                cur_byte   = bl_mask;
                cur_delay  = DLY_NONE;
                final_step = 1'b1;
            end
            KIND_LCD: begin
                cur_byte   = {nib, job.bl, ~k[0], 1'b0, lcd_rs};
                cur_delay  = !k[0] ? DLY_E_HIGH :
                             ((k[1] && lcd_long) ? DLY_LONG : DLY_E_LOW);
                final_step = unit_second && (k == 2'd3);
            end
            default: begin
                cur_byte   = '0;
                cur_delay  = DLY_NONE;
                final_step = 1'b1;
            end
        endcase
    end

    // Step counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_step      <= final_step ? '0 : r_step + 5'd1;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_byte  <= cur_byte;
            r_out_delay <= cur_delay;
            r_out_last  <= final_step;
            r_out_done  <= final_step && job.eos;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_delay, r_out_byte};
    assign o_m_tuser  = r_out_done;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/char_lcd_i2c_expander_driver.sv =====
// Top level of the character LCD expander driver: front end, job queue and
// back end. Depends on clcd_pkg, clcd_front, clcd_queue, clcd_back.
//
// Usage:
//   Slave stream (i_s_*): tdata[7:0] = text byte, tuser = op (1 = power-up
//   init), tlast = end of host string. Master stream (o_m_*): tdata[7:0] =
//   expander byte, tdata[19:8] = wait in microseconds after it, tlast = last
//   byte of that input, tuser = end-of-string echo on that last byte.
//   Config channel (i_cfg_*) writes line_length; write only while idle.
// Path: an accepted input is queued, then the back end registers its first expander byte.
// Throughput: the back end emits one expander byte per cycle while the output
//   is not stalled; a printable character expands to 4 expander bytes (8 with
//   the line-two jump), CR 8, TAB 4, BEL/BS 1 and init 31. LF is accepted and
//   produces nothing. The front end keeps accepting into a QUEUE_DEPTH-entry job
//   queue while the back end works, so the output byte rate sets the sustained rate.
// Reset: synchronous active low; line_length = 16, backlight off, column 0,
//   queue empty, no output valid.
// Stall: when i_m_tready is low the output byte holds, the back end waits,
//   and input is refused only once the job queue is full.
module char_lcd_i2c_expander_driver
    import clcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] char_byte
    input  logic                  i_s_tuser,   // [0] op
    input  logic                  i_s_tlast,   // end_of_string
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [23:0]           o_m_tdata,   // [7:0] bus_byte, [19:8] delay_us
    output logic                  o_m_tuser,   // [0] string_done
    output logic                  o_m_tlast,   // last
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [LINE_LEN_W-1:0] i_cfg_data   // line_length
);

    logic    push;
    logic    pop;
    logic    full;
    t_job    job;
    t_q_head head;

    clcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_job       (job)
    );

    clcd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head)
    );

    clcd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // String end is only flagged on the last byte of a transaction's expansion
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("string_done without last");

    // Within one expansion the back end never leaves a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("gap inside an expansion");

    // A popped job must have been at the queue head
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

// ===== dv/tb_char_lcd_i2c_expander_driver.sv =====
// Self-checking testbench for char_lcd_i2c_expander_driver: directed table, then random text,
// control and init requests across several line lengths, with random stalls on both streams.
// Depends on clcd_pkg and the RTL of the driver only.
`timescale 1ns / 1ps

module tb_char_lcd_i2c_expander_driver;
    import clcd_pkg::*;

    // Expander byte bits
    localparam logic [7:0]  BIT_E  = 8'h04;
    localparam logic [7:0]  BIT_RS = 8'h01;
    localparam logic [7:0]  BIT_BL = 8'h08;
    // Extra waits added after the last byte of a step
    localparam logic [11:0] WAIT_INIT = 12'd1000;
    localparam logic [11:0] WAIT_CMD  = 12'd2000;
    localparam int NUM_DIR_ROWS  = 24;
    localparam int RAND_ITEMS    = 336;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;

    // One expander byte as it leaves the master stream
    typedef struct packed {
        logic [7:0]  bus_byte;
        logic [11:0] delay_us;
        logic        last;
        logic        done;
    } t_bus_word;

    // Directed stimulus row; x_byte/x_dly give the first byte where it is obvious
    typedef struct packed {
        logic       cfg;
        logic [5:0] cfg_val;
        logic       op;
        logic [7:0] ch;
        logic       eos;
        logic       chk;
        logic [7:0] x_byte;
        logic [11:0] x_dly;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tuser;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data;

    // Shadow of the display state
    logic [5:0]  line_len;
    logic        bl_on;
    logic [5:0]  col;

    t_bus_word   step_words[$];
    t_bus_word   pending_bytes[$];
    int          err_count = 0;
    bit          tx_calm   = 1'b0;
    bit          rx_calm   = 1'b0;

    t_dir_row    dir_rows[NUM_DIR_ROWS];

    char_lcd_i2c_expander_driver u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [7:0] char_byte
        .i_s_tuser   (i_s_tuser),   // [0] op
        .i_s_tlast   (i_s_tlast),   // end_of_string
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // [7:0] bus_byte, [19:8] delay_us
        .o_m_tuser   (o_m_tuser),   // [0] string_done
        .o_m_tlast   (o_m_tlast),   // last
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)   // line_length
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Display predictor: builds the expander bytes of one request
    // ---------------------------------------------------------------
    function automatic void put_byte(input logic [7:0] b, input logic [11:0] us);
        t_bus_word w;
        w = '{bus_byte: b, delay_us: us, last: 1'b0, done: 1'b0};
        step_words.push_back(w);
    endfunction

    function automatic void stretch_wait(input logic [11:0] us);
        t_bus_word w;
        int        n;
        n = step_words.size();
        if (n > 0) begin
            w = step_words[n-1];
            w.delay_us = w.delay_us + us;
            step_words[n-1] = w;
        end
    endfunction

    function automatic logic [7:0] bl_bit();
        return bl_on ? BIT_BL : 8'h00;
    endfunction

    // E high then E low for one nibble
    function automatic void put_nibble(input logic [7:0] hi, input logic [7:0] rs);
        put_byte((hi & 8'hF0) | BIT_E | rs | bl_bit(), DLY_E_HIGH);
        put_byte((hi & 8'hF0) | rs | bl_bit(), DLY_E_LOW);
    endfunction

    function automatic void put_lcd_byte(input logic [7:0] v, input logic [7:0] rs);
        put_nibble(v, rs);
        put_nibble({v[3:0], 4'h0}, rs);
    endfunction

    function automatic void put_slow_cmd(input logic [7:0] v);
        put_lcd_byte(v, 8'h00);
        stretch_wait(WAIT_CMD);
    endfunction

    function automatic void put_backlight(input logic on);
        bl_on = on;
        put_byte(bl_bit(), DLY_NONE);
    endfunction

    function automatic void lcd_predict(input logic op, input logic [7:0] ch, input logic eos);
        t_bus_word w;
        int        lim;
        int        n;
        step_words.delete();
        if (op == OP_INIT) begin
            put_byte(8'h00, DLY_NONE);
            put_byte(8'h00, WAIT_INIT);
            for (int i = 0; i < 3; i++) begin
                put_nibble(8'h30, 8'h00);
                stretch_wait(WAIT_INIT);
            end
            put_nibble(8'h20, 8'h00);
            stretch_wait(WAIT_INIT);
            put_lcd_byte(8'h28, 8'h00);
            stretch_wait(WAIT_INIT);
            put_lcd_byte(8'h0C, 8'h00);
            stretch_wait(WAIT_INIT);
            put_lcd_byte(8'h06, 8'h00);
            stretch_wait(WAIT_CMD);
            put_slow_cmd(CMD_CLEAR);
            put_backlight(1'b1);
            put_slow_cmd(CMD_HOME);
            col = '0;
        end else begin
            case (ch)
                CHR_CR: begin
                    put_slow_cmd(CMD_CLEAR);
                    put_slow_cmd(CMD_HOME);
                    col = '0;
                end
                CHR_BEL: put_backlight(1'b1);
                CHR_BS:  put_backlight(1'b0);
                CHR_TAB: begin
                    put_slow_cmd(CMD_HOME);
                    col = '0;
                end
                CHR_LF: ;
                default: begin
                    // jump to line two once the column reaches the line length
                    if (col == line_len)
                        put_slow_cmd(CMD_LINE2);
                    put_lcd_byte(ch, BIT_RS);
                    lim = int'(line_len) + 1;
                    if (lim > int'(COL_MAX))
                        lim = int'(COL_MAX);
                    if (int'(col) < lim)
                        col = col + 6'd1;
                end
            endcase
        end
        // Flag the final byte and queue the whole step
        n = step_words.size();
        if (n > 0) begin
            w = step_words[n-1];
            w.last = 1'b1;
            w.done = eos;
            step_words[n-1] = w;
        end
        foreach (step_words[i])
            pending_bytes.push_back(step_words[i]);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic feed_request(input logic op, input logic [7:0] ch, input logic eos);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tuser  <= op;
        i_s_tlast  <= eos;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        lcd_predict(op, ch, eos);
    endtask

    // Stop sending and let every queued byte drain; LF leaves no byte to wait on
    task automatic wait_display_idle();
        i_s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_length(input logic [5:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        line_len = len;
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------
    initial begin
        dir_rows = '{
            '{1'b0, 6'd0,  OP_TEXT, CHR_BEL, 1'b1, 1'b1, 8'h08, DLY_NONE},
            '{1'b0, 6'd0,  OP_TEXT, CHR_BS,  1'b0, 1'b1, 8'h00, DLY_NONE},
            '{1'b0, 6'd0,  OP_INIT, 8'hA5,   1'b1, 1'b1, 8'h00, DLY_NONE},
            '{1'b0, 6'd0,  OP_TEXT, 8'h41,   1'b0, 1'b1, 8'h4D, DLY_E_HIGH},
            '{1'b0, 6'd0,  OP_TEXT, 8'h00,   1'b0, 1'b1, 8'h0D, DLY_E_HIGH},
            '{1'b0, 6'd0,  OP_TEXT, 8'hFF,   1'b0, 1'b1, 8'hFD, DLY_E_HIGH},
            '{1'b0, 6'd0,  OP_TEXT, CHR_CR,  1'b1, 1'b1, 8'h0C, DLY_E_HIGH},
            '{1'b0, 6'd0,  OP_TEXT, 8'h48,   1'b0, 1'b0, 8'h00, DLY_NONE},
            '{1'b0, 6'd0,  OP_TEXT, CHR_TAB, 1'b0, 1'b1, 8'h0C, DLY_E_HIGH},
            '{1'b0, 6'd0,  OP_TEXT, CHR_LF,  1'b1, 1'b0, 8'h00, DLY_NONE},
            // init with the backlight already on
            '{1'b0, 6'd0,  OP_INIT, 8'h5A,   1'b0, 1'b1, 8'h00, DLY_NONE},
            '{1'b0, 6'd0,  OP_TEXT, CHR_BS,  1'b0, 1'b1, 8'h00, DLY_NONE},
            // line length zero: jump before the first character
            '{1'b1, 6'd0,  OP_TEXT, 8'h78,   1'b0, 1'b1, 8'hC4, DLY_E_HIGH},
            '{1'b0, 6'd0,  OP_TEXT, 8'h79,   1'b0, 1'b0, 8'h00, DLY_NONE},
            '{1'b1, 6'd63, OP_TEXT, CHR_TAB, 1'b0, 1'b1, 8'h04, DLY_E_HIGH},
            '{1'b0, 6'd0,  OP_TEXT, 8'h7A,   1'b0, 1'b0, 8'h00, DLY_NONE},
            '{1'b1, 6'd3,  OP_TEXT, 8'h61,   1'b0, 1'b0, 8'h00, DLY_NONE},
            '{1'b0, 6'd0,  OP_TEXT, 8'h62,   1'b0, 1'b1, 8'h65, DLY_E_HIGH},
            // line length lowered below the column: no jump
            '{1'b1, 6'd2,  OP_TEXT, 8'h63,   1'b0, 1'b1, 8'h65, DLY_E_HIGH},
            '{1'b0, 6'd0,  OP_TEXT, 8'h64,   1'b0, 1'b0, 8'h00, DLY_NONE},
            '{1'b0, 6'd0,  OP_TEXT, CHR_CR,  1'b1, 1'b0, 8'h00, DLY_NONE},
            '{1'b1, 6'd40, OP_TEXT, 8'h80,   1'b0, 1'b0, 8'h00, DLY_NONE},
            '{1'b1, 6'd16, OP_TEXT, CHR_BEL, 1'b1, 1'b1, 8'h08, DLY_NONE},
            '{1'b0, 6'd0,  OP_TEXT, 8'h7F,   1'b1, 1'b0, 8'h00, DLY_NONE}
        };
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int         phase;
        int         counted;
        int         n_items;
        int         pick;
        logic [5:0] len;
        logic       op;
        logic [7:0] ch;
        logic       eos;
        bit         long_line;

        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= OP_TEXT;
        i_s_tlast   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        line_len = LINE_LEN_RST;
        bl_on    = 1'b0;
        col      = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows, first-byte check where the table gives one
        for (int r = 0; r < NUM_DIR_ROWS; r++) begin
            if (dir_rows[r].cfg) begin
                wait_display_idle();
                write_line_length(dir_rows[r].cfg_val);
            end
            feed_request(dir_rows[r].op, dir_rows[r].ch, dir_rows[r].eos);
            if (dir_rows[r].chk && (step_words.size() == 0 ||
                    step_words[0].bus_byte != dir_rows[r].x_byte ||
                    step_words[0].delay_us != dir_rows[r].x_dly)) begin
                $display("%0t: row %0d first byte: expected %02h/%0d, predicted %02h/%0d",
                         $time, r, dir_rows[r].x_byte, dir_rows[r].x_dly,
                         step_words.size() ? step_words[0].bus_byte : 8'h00,
                         step_words.size() ? step_words[0].delay_us : 12'd0);
                err_count++;
            end
        end

        // Random phases, each under a new line length
        phase   = 0;
        counted = 0;
        while (counted < RAND_ITEMS) begin
            wait_display_idle();
            case (phase)
                0:       len = 6'd16;
                1:       len = 6'd0;
                2:       len = 6'd63;
                3:       len = 6'd1;
                4:       len = 6'd40;
                default: len = 6'($urandom_range(0, 63));
            endcase
            write_line_length(len);
            tx_calm   = (phase % 3 == 1);
            rx_calm   = (phase % 4 == 2);
            // long lines: keep the column climbing to reach saturation
            long_line = (len >= 6'd32);
            n_items   = long_line ? 110 : 40;
            for (int k = 0; k < n_items && counted < RAND_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                op   = OP_TEXT;
                eos  = ($urandom_range(0, 3) == 0);
                ch   = 8'($urandom_range(0, 255));
                if (ch == CHR_CR || ch == CHR_TAB || ch == CHR_LF ||
                        ch == CHR_BEL || ch == CHR_BS)
                    ch ^= 8'h40;
                if (pick < 2 && !long_line)
                    op = OP_INIT;
                else if (pick < 7 && !long_line)
                    ch = CHR_CR;
                else if (pick < 12 && !long_line)
                    ch = CHR_TAB;
                else if (pick < 16)
                    ch = CHR_BEL;
                else if (pick < 20)
                    ch = CHR_BS;
                else if (pick < 24)
                    ch = CHR_LF;
                feed_request(op, ch, eos);
                if (!(op == OP_TEXT && ch == CHR_LF))
                    counted++;
            end
            phase++;
        end

        wait_display_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: random stalls, checks every accepted transaction
    // ---------------------------------------------------------------
    initial begin
        int        stall;
        t_bus_word want;
        i_m_tready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte: expected none, %s %02h delay %0d last %0b done %0b",
                         $time, "actual", o_m_tdata[7:0], o_m_tdata[19:8],
                         o_m_tlast, o_m_tuser);
                err_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_m_tdata[7:0] !== want.bus_byte || o_m_tdata[19:8] !== want.delay_us ||
                        o_m_tlast !== want.last || o_m_tuser !== want.done) begin
                    $display({"%0t: byte mismatch: expected %02h delay %0d last %0b done %0b,",
                              " actual %02h delay %0d last %0b done %0b"},
                             $time, want.bus_byte, want.delay_us, want.last, want.done,
                             o_m_tdata[7:0], o_m_tdata[19:8], o_m_tlast, o_m_tuser);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
